### rtl/core/lsbi_pkg.sv
// Shared types and constants for the laser slew blank inserter.
// Holds the configuration, command and status structs used by every module.
// No dependencies.
package lsbi_pkg;

  // Result limits per accepted item and per run phase
  localparam int unsigned MaxRes  = 56;
  localparam int unsigned PreCap  = 8;
  localparam int unsigned PostCap = 16;
  localparam int unsigned SlewCap = 32;
  localparam int unsigned CntW    = 6;

  // Register reset values
  localparam logic [3:0]  PreBlanksRst  = 4'd3;
  localparam logic [4:0]  PostBlanksRst = 5'd16;
  localparam logic [15:0] MinDistRst    = 16'd50;
  localparam logic [15:0] SlewStepRst   = 16'd3276;

  // APB register map, one word per register
  localparam int unsigned AddrW = 4;

  typedef enum logic [1:0] {
    RegPreBlanks  = 2'd0,
    RegPostBlanks = 2'd1,
    RegMinDist    = 2'd2,
    RegSlewStep   = 2'd3
  } reg_idx_e;

  // Source of a generated result
  typedef enum logic [1:0] {
    EmitPoint = 2'd0,
    EmitSrc   = 2'd1,
    EmitTgt   = 2'd2
  } emit_sel_e;

  typedef struct packed {
    logic [3:0]  pre_blanks;
    logic [4:0]  post_blanks;
    logic [15:0] min_dist;
    logic [15:0] slew_step;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic      load_in;
    logic      load_home;
    logic      rem_load;
    logic      rem_step;
    logic      prev_from_pt;
    logic      prev_from_tgt;
    logic      frame_reset;
    logic      hold_we;
    emit_sel_e emit_sel;
    logic      out_we;
    logic      out_from_hold;
    logic      out_run_last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic       pt_lit;
    logic       pt_last;
    logic       prev_lit;
    logic       fho;
    logic       far;
    logic       slew_end;
    logic [3:0] pre_lim;
    logic [4:0] post_lim;
  } sts_t;

endpackage

### rtl/core/lsbi_regs.sv
// APB configuration registers of the laser slew blank inserter.
// Depends on lsbi_pkg for the register map and the cfg_t struct.
module lsbi_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lsbi_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output lsbi_pkg::cfg_t              cfg_o
);

  lsbi_pkg::cfg_t   cfg_q;
  lsbi_pkg::reg_idx_e idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign idx    = lsbi_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  // Write the addressed register in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pre_blanks  <= lsbi_pkg::PreBlanksRst;
      cfg_q.post_blanks <= lsbi_pkg::PostBlanksRst;
      cfg_q.min_dist    <= lsbi_pkg::MinDistRst;
      cfg_q.slew_step   <= lsbi_pkg::SlewStepRst;
    end else if (wr_en) begin
      unique case (idx)
        lsbi_pkg::RegPreBlanks:  cfg_q.pre_blanks  <= pwdata[3:0];
        lsbi_pkg::RegPostBlanks: cfg_q.post_blanks <= pwdata[4:0];
        lsbi_pkg::RegMinDist:    cfg_q.min_dist    <= pwdata[15:0];
        lsbi_pkg::RegSlewStep:   cfg_q.slew_step   <= pwdata[15:0];
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (idx)
      lsbi_pkg::RegPreBlanks:  prdata = {28'd0, cfg_q.pre_blanks};
      lsbi_pkg::RegPostBlanks: prdata = {27'd0, cfg_q.post_blanks};
      lsbi_pkg::RegMinDist:    prdata = {16'd0, cfg_q.min_dist};
      lsbi_pkg::RegSlewStep:   prdata = {16'd0, cfg_q.slew_step};
    endcase
  end

endmodule

### rtl/core/lsbi_datapath.sv
// Datapath of the laser slew blank inserter: point, previous position,
// slew distance, remaining slew counter, holdback and output registers.
// Depends on lsbi_pkg for cfg_t, cmd_t and sts_t.
module lsbi_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lsbi_pkg::cfg_t        cfg_i,
  input  lsbi_pkg::cmd_t        cmd_i,
  output lsbi_pkg::sts_t        sts_o,
  input  logic signed [15:0]    pos_x_i,
  input  logic signed [15:0]    pos_y_i,
  input  logic [15:0]           red_i,
  input  logic [15:0]           green_i,
  input  logic [15:0]           blue_i,
  input  logic                  frame_last_i,
  output logic signed [15:0]    out_x_o,
  output logic signed [15:0]    out_y_o,
  output logic [15:0]           out_red_o,
  output logic [15:0]           out_green_o,
  output logic [15:0]           out_blue_o,
  output logic                  inserted_blank_o,
  output logic                  run_last_o,
  output logic                  frame_done_o
);

  // Accepted point
  logic [15:0] pt_x_q, pt_y_q, pt_r_q, pt_g_q, pt_b_q;
  logic        pt_last_q;
  // Previous position and frame state
  logic [15:0] prev_x_q, prev_y_q;
  logic        prev_lit_q, fho_q;
  // Slew target and remaining distance
  logic [15:0] tgt_x_q, tgt_y_q;
  logic [15:0] rem_q;
  // Holdback stage and output stage
  logic [15:0] hold_x_q, hold_y_q, hold_r_q, hold_g_q, hold_b_q;
  logic        hold_ins_q;
  logic [15:0] out_x_q, out_y_q, out_r_q, out_g_q, out_b_q;
  logic        out_ins_q, out_rl_q, out_fd_q;

  logic signed [16:0] dx, dy;
  logic [16:0]        ax, ay;
  logic [15:0]        cheb_dist;
  logic [15:0]        em_x, em_y, em_r, em_g, em_b;
  logic               em_ins;

  // Chebyshev distance from previous position to target
  assign dx   = $signed({prev_x_q[15], prev_x_q}) - $signed({tgt_x_q[15], tgt_x_q});
  assign dy   = $signed({prev_y_q[15], prev_y_q}) - $signed({tgt_y_q[15], tgt_y_q});
  assign ax   = dx[16] ? 17'(-dx) : 17'(dx);
  assign ay   = dy[16] ? 17'(-dy) : 17'(dy);
  assign cheb_dist = (ax > ay) ? ax[15:0] : ay[15:0];

  // Status toward the controller
  always_comb begin
    sts_o.pt_lit   = |{pt_r_q, pt_g_q, pt_b_q};
    sts_o.pt_last  = pt_last_q;
    sts_o.prev_lit = prev_lit_q;
    sts_o.fho      = fho_q;
    sts_o.far      = cheb_dist > cfg_i.min_dist;
    sts_o.slew_end = rem_q <= cfg_i.slew_step;
    sts_o.pre_lim  = (cfg_i.pre_blanks > 4'(lsbi_pkg::PreCap)) ?
                     4'(lsbi_pkg::PreCap) : cfg_i.pre_blanks;
    sts_o.post_lim = (cfg_i.post_blanks > 5'(lsbi_pkg::PostCap)) ?
                     5'(lsbi_pkg::PostCap) : cfg_i.post_blanks;
  end

  // Select the generated result
  always_comb begin
    unique case (cmd_i.emit_sel)
      lsbi_pkg::EmitPoint: begin
        em_x = pt_x_q;   em_y = pt_y_q;
        em_r = pt_r_q;   em_g = pt_g_q;   em_b = pt_b_q;
        em_ins = 1'b0;
      end
      lsbi_pkg::EmitSrc: begin
        em_x = prev_x_q; em_y = prev_y_q;
        em_r = '0;       em_g = '0;       em_b = '0;
        em_ins = 1'b1;
      end
      default: begin
        em_x = tgt_x_q;  em_y = tgt_y_q;
        em_r = '0;       em_g = '0;       em_b = '0;
        em_ins = 1'b1;
      end
    endcase
  end

  // Latch the point, target and remaining distance
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      pt_x_q    <= pos_x_i;
      pt_y_q    <= pos_y_i;
      pt_r_q    <= red_i;
      pt_g_q    <= green_i;
      pt_b_q    <= blue_i;
      pt_last_q <= frame_last_i;
      tgt_x_q   <= pos_x_i;
      tgt_y_q   <= pos_y_i;
    end else if (cmd_i.load_home) begin
      tgt_x_q <= '0;
      tgt_y_q <= '0;
    end
    if (cmd_i.rem_load) begin
      rem_q <= cheb_dist;
    end else if (cmd_i.rem_step) begin
      rem_q <= cfg_i.slew_step < rem_q ? rem_q - cfg_i.slew_step : '0;
    end
  end

  // Update previous position and frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q   <= '0;
      prev_y_q   <= '0;
      prev_lit_q <= 1'b1;
      fho_q      <= 1'b0;
    end else if (cmd_i.frame_reset) begin
      prev_x_q   <= '0;
      prev_y_q   <= '0;
      prev_lit_q <= 1'b1;
      fho_q      <= 1'b0;
    end else if (cmd_i.prev_from_pt) begin
      prev_x_q   <= pt_x_q;
      prev_y_q   <= pt_y_q;
      prev_lit_q <= 1'b1;
      fho_q      <= 1'b1;
    end else if (cmd_i.prev_from_tgt) begin
      prev_x_q   <= tgt_x_q;
      prev_y_q   <= tgt_y_q;
      prev_lit_q <= 1'b0;
      fho_q      <= 1'b1;
    end
  end

  // Hold the newest result, advance the older one or pass a result straight to the output stage
  always_ff @(posedge clk_i) begin
    if (cmd_i.hold_we) begin
      hold_x_q   <= em_x;
      hold_y_q   <= em_y;
      hold_r_q   <= em_r;
      hold_g_q   <= em_g;
      hold_b_q   <= em_b;
      hold_ins_q <= em_ins;
    end
    if (cmd_i.out_we) begin
      if (cmd_i.out_from_hold) begin
        out_x_q   <= hold_x_q;
        out_y_q   <= hold_y_q;
        out_r_q   <= hold_r_q;
        out_g_q   <= hold_g_q;
        out_b_q   <= hold_b_q;
        out_ins_q <= hold_ins_q;
      end else begin
        out_x_q   <= em_x;
        out_y_q   <= em_y;
        out_r_q   <= em_r;
        out_g_q   <= em_g;
        out_b_q   <= em_b;
        out_ins_q <= em_ins;
      end
      out_rl_q <= cmd_i.out_run_last;
      out_fd_q <= cmd_i.out_run_last && pt_last_q;
    end
  end

  assign out_x_o          = out_x_q;
  assign out_y_o          = out_y_q;
  assign out_red_o        = out_r_q;
  assign out_green_o      = out_g_q;
  assign out_blue_o       = out_b_q;
  assign inserted_blank_o = out_ins_q;
  assign run_last_o       = out_rl_q;
  assign frame_done_o     = out_fd_q;

endmodule

### rtl/core/lsbi_ctrl.sv
// Controller of the laser slew blank inserter: item handshake, run sequencing,
// result counting, holdback and output valid flags.
// Depends on lsbi_pkg for cmd_t, sts_t and the result limits.
module lsbi_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  lsbi_pkg::sts_t  sts_i,
  output lsbi_pkg::cmd_t  cmd_o
);

  typedef enum logic [8:0] {
    SIdle    = 9'b000000001,
    SEval    = 9'b000000010,
    SHomeChk = 9'b000000100,
    SHomeEv  = 9'b000001000,
    SPre     = 9'b000010000,
    SSlew    = 9'b000100000,
    SPost    = 9'b001000000,
    SRunEnd  = 9'b010000000,
    SFlush   = 9'b100000000
  } state_e;

  state_e                      state_q, state_d;
  logic [lsbi_pkg::CntW-1:0]   n_q, n_d;
  logic [lsbi_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic                        home_run_q, home_run_d;
  logic                        hold_v_q, hold_v_d;
  logic                        out_v_q, out_v_d;
  logic                        out_free, can_push, cap_hit, accept;

  assign out_free    = !out_v_q || out_ready_i;
  assign can_push    = !hold_v_q || out_free;
  assign cap_hit     = n_q == lsbi_pkg::CntW'(lsbi_pkg::MaxRes);
  assign in_ready_o  = state_q == SIdle;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_v_q;

  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    cnt_d      = cnt_q;
    home_run_d = home_run_q;
    hold_v_d   = hold_v_q;
    out_v_d    = out_v_q && !out_ready_i;
    cmd_o      = '0;

    unique case (state_q)
      SIdle: begin
        if (accept) begin
          cmd_o.load_in = 1'b1;
          n_d           = '0;
          state_d       = SEval;
        end
      end

      // Lit points pass; a dark point after a lit one may start a slew run
      SEval: begin
        if (sts_i.pt_lit) begin
          cmd_o.emit_sel = lsbi_pkg::EmitPoint;
          if (!sts_i.pt_last) begin
            if (out_free) begin
              cmd_o.out_we       = 1'b1;
              cmd_o.out_run_last = 1'b1;
              cmd_o.prev_from_pt = 1'b1;
              out_v_d            = 1'b1;
              state_d            = SIdle;
            end
          end else begin
            cmd_o.hold_we      = 1'b1;
            cmd_o.prev_from_pt = 1'b1;
            hold_v_d           = 1'b1;
            n_d                = n_q + 1'b1;
            state_d            = SHomeChk;
          end
        end else if (sts_i.prev_lit && sts_i.far) begin
          cmd_o.rem_load = 1'b1;
          home_run_d     = 1'b0;
          cnt_d          = '0;
          state_d        = SPre;
        end else if (sts_i.pt_last) begin
          state_d = SHomeChk;
        end else begin
          state_d = SIdle;
        end
      end

      // At frame end, slew home if the frame produced anything and home is far enough
      SHomeChk: begin
        if (sts_i.pt_last && sts_i.fho) begin
          cmd_o.load_home = 1'b1;
          state_d         = SHomeEv;
        end else begin
          cmd_o.frame_reset = sts_i.pt_last;
          state_d           = SFlush;
        end
      end

      SHomeEv: begin
        if (sts_i.far) begin
          cmd_o.rem_load = 1'b1;
          home_run_d     = 1'b1;
          cnt_d          = '0;
          state_d        = SPre;
        end else begin
          cmd_o.frame_reset = 1'b1;
          state_d           = SFlush;
        end
      end

      // Dark copies at the old position
      SPre: begin
        cmd_o.emit_sel = lsbi_pkg::EmitSrc;
        if (cap_hit) begin
          state_d = SRunEnd;
        end else if (cnt_q == lsbi_pkg::CntW'(sts_i.pre_lim)) begin
          cnt_d   = '0;
          state_d = SSlew;
        end else if (can_push) begin
          cmd_o.hold_we = 1'b1;
          cnt_d         = cnt_q + 1'b1;
        end
      end

      // One dark copy at the target per slew step
      SSlew: begin
        cmd_o.emit_sel = lsbi_pkg::EmitTgt;
        if (cap_hit) begin
          state_d = SRunEnd;
        end else if (can_push) begin
          cmd_o.hold_we  = 1'b1;
          cmd_o.rem_step = 1'b1;
          cnt_d          = cnt_q + 1'b1;
          if (sts_i.slew_end ||
              cnt_q == lsbi_pkg::CntW'(lsbi_pkg::SlewCap - 1)) begin
            cnt_d   = '0;
            state_d = SPost;
          end
        end
      end

      // Extra dark copies at the target
      SPost: begin
        cmd_o.emit_sel = lsbi_pkg::EmitTgt;
        if (cap_hit || cnt_q == lsbi_pkg::CntW'(sts_i.post_lim)) begin
          state_d = SRunEnd;
        end else if (can_push) begin
          cmd_o.hold_we = 1'b1;
          cnt_d         = cnt_q + 1'b1;
        end
      end

      SRunEnd: begin
        if (home_run_q) begin
          cmd_o.frame_reset = 1'b1;
          state_d           = SFlush;
        end else begin
          cmd_o.prev_from_tgt = 1'b1;
          state_d             = SHomeChk;
        end
      end

      // Release the held result as the last one of this item
      SFlush: begin
        if (!hold_v_q) begin
          state_d = SIdle;
        end else if (out_free) begin
          cmd_o.out_we        = 1'b1;
          cmd_o.out_from_hold = 1'b1;
          cmd_o.out_run_last  = 1'b1;
          out_v_d             = 1'b1;
          hold_v_d            = 1'b0;
          state_d             = SIdle;
        end
      end

      default: state_d = SIdle;
    endcase

    // A push into the holdback stage moves the older result out
    if (cmd_o.hold_we) begin
      hold_v_d = 1'b1;
      if (state_q != SEval) begin
        n_d = n_q + 1'b1;
      end
      if (hold_v_q) begin
        cmd_o.out_we        = 1'b1;
        cmd_o.out_from_hold = 1'b1;
        out_v_d             = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      n_q        <= '0;
      cnt_q      <= '0;
      home_run_q <= 1'b0;
      hold_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      n_q        <= n_d;
      cnt_q      <= cnt_d;
      home_run_q <= home_run_d;
      hold_v_q   <= hold_v_d;
      out_v_q    <= out_v_d;
    end
  end

  // The holdback stage is empty whenever a new item may enter
  a_idle_hold_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SIdle) |-> !hold_v_q)
    else $error("holdback stage occupied while idle");

  // Never more results per item than the limit
  a_res_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= lsbi_pkg::CntW'(lsbi_pkg::MaxRes))
    else $error("result count above limit");

  // A held result only moves out when the output stage can take it
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_we && out_v_q) |-> out_ready_i)
    else $error("output stage overwritten");

  // An accepted item is evaluated in the next cycle
  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == SEval))
    else $error("accepted item not evaluated");

endmodule

### rtl/core/laser_slew_blank_inserter.sv
// Laser slew blank inserter, top level. A lit point that does not end a frame
// is accepted and then placed in the output register once it is free.
// A dark point that is dropped is accepted and then evaluated. A point that starts
// a slew run goes through run setup and the pre, slew and post phases; the single
// result generator emits one point per cycle while the holdback and output stages
// can take it. A frame-end point adds the home check, the home run if any and a
// flush step to release its last result. The output register lets the next point
// be accepted while a result still waits.
// Depends on lsbi_pkg, lsbi_regs, lsbi_datapath and lsbi_ctrl.
module laser_slew_blank_inserter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // APB configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lsbi_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // Point input channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [15:0]          pos_x_i,
  input  logic signed [15:0]          pos_y_i,
  input  logic [15:0]                 red_i,
  input  logic [15:0]                 green_i,
  input  logic [15:0]                 blue_i,
  input  logic                        frame_last_i,
  // Result output channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [15:0]          out_x_o,
  output logic signed [15:0]          out_y_o,
  output logic [15:0]                 out_red_o,
  output logic [15:0]                 out_green_o,
  output logic [15:0]                 out_blue_o,
  output logic                        inserted_blank_o,
  output logic                        run_last_o,
  output logic                        frame_done_o
);

  lsbi_pkg::cfg_t cfg;
  lsbi_pkg::cmd_t cmd;
  lsbi_pkg::sts_t sts;

  lsbi_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lsbi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lsbi_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .red_i            (red_i),
    .green_i          (green_i),
    .blue_i           (blue_i),
    .frame_last_i     (frame_last_i),
    .out_x_o          (out_x_o),
    .out_y_o          (out_y_o),
    .out_red_o        (out_red_o),
    .out_green_o      (out_green_o),
    .out_blue_o       (out_blue_o),
    .inserted_blank_o (inserted_blank_o),
    .run_last_o       (run_last_o),
    .frame_done_o     (frame_done_o)
  );

endmodule

### dv/laser_slew_blank_inserter_tb.sv
// Testbench for laser_slew_blank_inserter: streams directed and random points,
// predicts the blanking runs per point and checks each emitted point in order.
// Depends on lsbi_pkg and the laser_slew_blank_inserter RTL.
module laser_slew_blank_inserter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DrainTail   = 100;
  localparam int HoldCycles  = 400;
  localparam int StallLimit  = 3000;
  localparam int DarkPct     = 30;
  localparam int LastPct     = 8;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        r;
    logic [15:0]        g;
    logic [15:0]        b;
    logic               last;
  } point_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        r;
    logic [15:0]        g;
    logic [15:0]        b;
    logic               ins;
    logic               run_last;
    logic               frame_done;
  } result_t;

  // Blanking predictor plus in-order result checker
  class blank_run_scoreboard;
    logic [3:0]         pre_blanks  = lsbi_pkg::PreBlanksRst;
    logic [4:0]         post_blanks = lsbi_pkg::PostBlanksRst;
    logic [15:0]        min_dist    = lsbi_pkg::MinDistRst;
    logic [15:0]        slew_step   = lsbi_pkg::SlewStepRst;
    logic signed [15:0] prev_x      = '0;
    logic signed [15:0] prev_y      = '0;
    bit                 prev_lit    = 1'b1;
    bit                 frame_busy  = 1'b0;
    result_t            pending_results[$];
    int                 fail_count, points_seen, results_checked, blanks_seen, frames_closed;

    function void set_reg(lsbi_pkg::reg_idx_e idx, logic [31:0] val);
      case (idx)
        lsbi_pkg::RegPreBlanks:  pre_blanks  = val[3:0];
        lsbi_pkg::RegPostBlanks: post_blanks = val[4:0];
        lsbi_pkg::RegMinDist:    min_dist    = val[15:0];
        lsbi_pkg::RegSlewStep:   slew_step   = val[15:0];
        default: ;
      endcase
    endfunction

    // Append one result, dropping anything past the per-point limit
    function void add_result(ref result_t run[$], input logic signed [15:0] x, y,
                             input logic [15:0] r, g, b, input logic ins);
      result_t item;
      if (run.size() < lsbi_pkg::MaxRes) begin
        item = '{x, y, r, g, b, ins, 1'b0, 1'b0};
        run  = {run, item};
      end
    endfunction

    // Insert the blank run toward (tx,ty) when the jump is far enough
    function bit add_slew(ref result_t run[$], input logic signed [15:0] tx, ty);
      int dx, dy;
      int unsigned span, steps, pre, post;
      dx = int'(prev_x) - int'(tx);
      dy = int'(prev_y) - int'(ty);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      span = (dx > dy) ? dx : dy;
      if (span <= min_dist) return 1'b0;
      steps = (slew_step == 0) ? lsbi_pkg::SlewCap : (span + slew_step - 1) / slew_step;
      if (steps > lsbi_pkg::SlewCap) steps = lsbi_pkg::SlewCap;
      pre  = (pre_blanks > lsbi_pkg::PreCap) ? lsbi_pkg::PreCap : pre_blanks;
      post = (post_blanks > lsbi_pkg::PostCap) ? lsbi_pkg::PostCap : post_blanks;
      repeat (pre) add_result(run, prev_x, prev_y, '0, '0, '0, 1'b1);
      repeat (steps + post) add_result(run, tx, ty, '0, '0, '0, 1'b1);
      return 1'b1;
    endfunction

    // Work out the results one accepted point causes and queue them
    function void accept_point(point_t p);
      result_t run[$];
      bit lit;
      lit = (p.r | p.g | p.b) != 16'h0;
      points_seen++;
      if (lit) begin
        add_result(run, p.x, p.y, p.r, p.g, p.b, 1'b0);
        prev_x   = p.x;
        prev_y   = p.y;
        prev_lit = 1'b1;
      end else if (prev_lit) begin
        if (add_slew(run, p.x, p.y)) begin
          prev_x   = p.x;
          prev_y   = p.y;
          prev_lit = 1'b0;
        end
      end
      if (run.size() > 0) frame_busy = 1'b1;
      // Return home at frame end
      if (p.last) begin
        if (frame_busy) void'(add_slew(run, '0, '0));
        prev_x     = '0;
        prev_y     = '0;
        prev_lit   = 1'b1;
        frame_busy = 1'b0;
      end
      if (run.size() > 0) begin
        run[run.size()-1].run_last   = 1'b1;
        run[run.size()-1].frame_done = p.last;
      end
      pending_results = {pending_results, run};
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected 'h%04h, got 'h%04h", name, want, got);
        fail_count++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $error("result with no expectation: x 'h%04h y 'h%04h", got.x, got.y);
        fail_count++;
        return;
      end
      want = pending_results.pop_front();
      results_checked++;
      if (want.ins) blanks_seen++;
      if (want.frame_done) frames_closed++;
      compare_field("out_x", want.x, got.x);
      compare_field("out_y", want.y, got.y);
      compare_field("out_red", want.r, got.r);
      compare_field("out_green", want.g, got.g);
      compare_field("out_blue", want.b, got.b);
      compare_field("inserted_blank", 16'(want.ins), 16'(got.ins));
      compare_field("run_last", 16'(want.run_last), 16'(got.run_last));
      compare_field("frame_done", 16'(want.frame_done), 16'(got.frame_done));
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni        = 1'b0;
  logic                        psel          = 1'b0;
  logic                        penable       = 1'b0;
  logic                        pwrite        = 1'b0;
  logic [lsbi_pkg::AddrW-1:0]  paddr         = '0;
  logic [31:0]                 pwdata        = '0;
  logic [31:0]                 prdata;
  logic                        pready;
  logic                        in_valid_i    = 1'b0;
  logic                        in_ready_o;
  logic signed [15:0]          pos_x_i       = '0;
  logic signed [15:0]          pos_y_i       = '0;
  logic [15:0]                 red_i         = '0;
  logic [15:0]                 green_i       = '0;
  logic [15:0]                 blue_i        = '0;
  logic                        frame_last_i  = 1'b0;
  logic                        out_valid_o;
  logic                        out_ready_i   = 1'b0;
  logic signed [15:0]          out_x_o;
  logic signed [15:0]          out_y_o;
  logic [15:0]                 out_red_o;
  logic [15:0]                 out_green_o;
  logic [15:0]                 out_blue_o;
  logic                        inserted_blank_o;
  logic                        run_last_o;
  logic                        frame_done_o;

  blank_run_scoreboard sb = new();

  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;
  bit                 hold_req      = 1'b0;
  int                 hold_left     = 0;
  int                 stall_count   = 0;
  logic signed [15:0] gen_x         = '0;
  logic signed [15:0] gen_y         = '0;
  point_t             directed_pts[$];

  laser_slew_blank_inserter dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Record accepted points and check emitted results
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      sb.accept_point('{pos_x_i, pos_y_i, red_i, green_i, blue_i, frame_last_i});
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result('{out_x_o, out_y_o, out_red_o, out_green_o, out_blue_o,
                        inserted_blank_o, run_last_o, frame_done_o});
  end

  // Drive out_ready: random stalls, or a long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // End the run if nothing moves on either channel for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_count <= 0;
      else stall_count <= stall_count + 1;
      if (stall_count >= StallLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(lsbi_pkg::reg_idx_e idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic send_point(point_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    pos_x_i      <= p.x;
    pos_y_i      <= p.y;
    red_i        <= p.r;
    green_i      <= p.g;
    blue_i       <= p.b;
    frame_last_i <= p.last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid, wait for every expected point, then let the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainTail) @(posedge clk_i);
  endtask

  function automatic point_t mk_point(int x, int y, logic [15:0] r, g, b, logic last);
    return '{16'(x), 16'(y), r, g, b, last};
  endfunction

  function automatic logic [15:0] rand_color();
    case ($urandom_range(3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // Random frame content: mostly lit points, some dark jumps and frame ends
  function automatic point_t rand_point();
    point_t p;
    int     t;
    case ($urandom_range(3))
      0: begin
        p.x = 16'($urandom_range(65535));
        p.y = 16'($urandom_range(65535));
      end
      1: begin
        t   = int'(gen_x) + int'($urandom_range(120)) - 60;
        p.x = t[15:0];
        t   = int'(gen_y) + int'($urandom_range(120)) - 60;
        p.y = t[15:0];
      end
      2: begin
        p.x = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        p.y = $urandom_range(1) ? 16'sh0000 : 16'($urandom_range(65535));
      end
      default: begin
        p.x = 16'(int'($urandom_range(16000)) - 8000);
        p.y = 16'(int'($urandom_range(16000)) - 8000);
      end
    endcase
    if ($urandom_range(99) < DarkPct) begin
      p.r = '0;
      p.g = '0;
      p.b = '0;
    end else begin
      p.r = rand_color();
      p.g = rand_color();
      p.b = rand_color();
      if ((p.r | p.g | p.b) == 16'h0) p.b = 16'($urandom_range(65535, 1));
    end
    p.last = ($urandom_range(99) < LastPct);
    gen_x  = p.x;
    gen_y  = p.y;
    return p;
  endfunction

  task automatic send_random(int count);
    repeat (count) send_point(rand_point());
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: pass-through, drops, threshold edge, home runs
    send_idle_pct = 12;
    recv_idle_pct = 56;
    directed_pts = '{
      mk_point(0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0),
      mk_point(32767, -32768, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0),
      mk_point(-32768, 32767, 16'h0000, 16'h0000, 16'h0000, 1'b0),
      mk_point(0, 0, 16'h0000, 16'h0000, 16'h0000, 1'b0),
      mk_point(-32768, 32767, 16'h8001, 16'h0000, 16'h0000, 1'b0),
      mk_point(-32718, 32767, 16'h0000, 16'h0000, 16'h0000, 1'b0),
      mk_point(-32717, 32767, 16'h0000, 16'h0000, 16'h0000, 1'b0),
      mk_point(100, -100, 16'h0000, 16'h0000, 16'h0001, 1'b1),
      mk_point(0, 0, 16'h0000, 16'h0000, 16'h0000, 1'b1),
      mk_point(30, 30, 16'h0000, 16'h1234, 16'h0000, 1'b1),
      mk_point(16384, 0, 16'h0000, 16'hFFFF, 16'h0000, 1'b0),
      mk_point(16384, 0, 16'h0000, 16'h0000, 16'h0000, 1'b0),
      mk_point(-1, -1, 16'h0000, 16'h0000, 16'h0000, 1'b1),
      mk_point(-16384, 8000, 16'hFFFF, 16'h0000, 16'h0000, 1'b0),
      mk_point(-16384, 8000, 16'h0000, 16'h0000, 16'h0000, 1'b1),
      mk_point(1, 1, 16'h0001, 16'h0001, 16'h0001, 1'b0),
      mk_point(-1, -1, 16'h8000, 16'h7FFF, 16'h0F0F, 1'b0),
      mk_point(32767, 32767, 16'h0000, 16'h0000, 16'h0000, 1'b0),
      mk_point(-32768, -32768, 16'h0000, 16'h0000, 16'h0000, 1'b0),
      mk_point(21845, -21846, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b1)
    };
    foreach (directed_pts[i]) send_point(directed_pts[i]);
    send_random(50);
    drain();

    // Largest counts: runs hit the per-point limit
    write_reg(lsbi_pkg::RegPreBlanks, 32'd15);
    write_reg(lsbi_pkg::RegPostBlanks, 32'd31);
    write_reg(lsbi_pkg::RegMinDist, 32'd0);
    write_reg(lsbi_pkg::RegSlewStep, 32'd1);
    directed_pts = '{
      mk_point(32767, 32767, 16'h00FF, 16'h0000, 16'h0000, 1'b0),
      mk_point(-32768, -32768, 16'h0000, 16'h0000, 16'h0000, 1'b1),
      mk_point(-32768, 0, 16'h0000, 16'hFF00, 16'h0000, 1'b1),
      mk_point(5, 5, 16'h0000, 16'h0000, 16'h0000, 1'b0)
    };
    foreach (directed_pts[i]) send_point(directed_pts[i]);
    // Hold off the output while points keep coming
    hold_req = 1'b1;
    send_random(30);
    drain();

    // No pre or post blanks, zero step saturates the slew count
    send_idle_pct = 56;
    recv_idle_pct = 12;
    write_reg(lsbi_pkg::RegPreBlanks, 32'd0);
    write_reg(lsbi_pkg::RegPostBlanks, 32'd0);
    write_reg(lsbi_pkg::RegMinDist, 32'd1000);
    write_reg(lsbi_pkg::RegSlewStep, 32'd0);
    send_random(40);
    drain();

    // Threshold at maximum: nothing inserted
    write_reg(lsbi_pkg::RegPreBlanks, 32'd8);
    write_reg(lsbi_pkg::RegPostBlanks, 32'd16);
    write_reg(lsbi_pkg::RegMinDist, 32'd65535);
    write_reg(lsbi_pkg::RegSlewStep, 32'd65535);
    send_random(30);
    drain();

    // Random legal settings, both sides at full rate
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(lsbi_pkg::RegPreBlanks, 32'($urandom_range(8)));
    write_reg(lsbi_pkg::RegPostBlanks, 32'($urandom_range(16)));
    write_reg(lsbi_pkg::RegMinDist, 32'($urandom_range(2000)));
    write_reg(lsbi_pkg::RegSlewStep, 32'($urandom_range(65535, 2048)));
    send_random(50);
    drain();

    $display("Run covered %0d points and %0d results (%0d inserted blanks, %0d frame ends)",
             sb.points_seen, sb.results_checked, sb.blanks_seen, sb.frames_closed);
    $display("across five register settings with stalls on both sides; %0d mismatches",
             sb.fail_count);
    if (sb.fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
